// ===== src/sfbd_pkg.sv =====
`timescale 1ns / 1ps

package sfbd_pkg;

  localparam int RING_DEPTH_DEF  = 4096;
  localparam int BLOCK_SIZE_DEF  = 512;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int SAMPLE_W   = 16;
  localparam int FILL_W     = 13;
  localparam int STAT_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [FILL_W-1:0] QUEUE_LIMIT_RST = 13'd4096;

  localparam logic [1:0] CMD_WRITE       = 2'd0;
  localparam logic [1:0] CMD_READ        = 2'd1;
  localparam logic [1:0] CMD_FLUSH       = 2'd2;
  localparam logic [1:0] CMD_RESET_STATS = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYBACK_PAUSED = 2'd1;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       accepted;
    logic [FILL_W-1:0]          fill_level;
    logic [STAT_W-1:0]          underrun_total;
    logic [STAT_W-1:0]          overrun_total;
    logic [FILL_W-1:0]          fill_min;
    logic [FILL_W-1:0]          fill_max;
    logic [STAT_W-1:0]          refill_total;
    logic [STAT_W-1:0]          silence_total;
  } rsp_t;

  // Per-item status handed from the control path to the output pipeline.
  typedef struct packed {
    logic                accepted;
    logic                pop;
    logic [FILL_W-1:0]   fill_level;
    logic [STAT_W-1:0]   underrun_total;
    logic [STAT_W-1:0]   overrun_total;
    logic [FILL_W-1:0]   fill_min;
    logic [FILL_W-1:0]   fill_max;
    logic [STAT_W-1:0]   refill_total;
    logic [STAT_W-1:0]   silence_total;
  } status_t;

endpackage

// ===== src/stereo_audio_fifo_block_drain.sv =====
`timescale 1ns / 1ps
// A result passes from the ring read into s1, then into the output register, before it
// can transfer. One item per cycle unless req_stall is high (s1 full, output stalled);
// the ring RAM takes one write or one read each cycle.
// Reset (rst, synchronous): indices, fill, block position and all statistics go to zero,
// queue_limit to 4096, playback unpaused. The ring contents are not cleared; only
// queued entries are ever read.

module stereo_audio_fifo_block_drain #(
  parameter int RING_DEPTH  = sfbd_pkg::RING_DEPTH_DEF,
  parameter int BLOCK_SIZE  = sfbd_pkg::BLOCK_SIZE_DEF,
  parameter int SAMPLE_BITS = sfbd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  sfbd_pkg::req_t                    req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output sfbd_pkg::rsp_t                    rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sfbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfbd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SAMPLE_W = sfbd_pkg::SAMPLE_W;
  localparam int STORE_W  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int IDX_W    = $clog2(RING_DEPTH);

  logic [sfbd_pkg::FILL_W-1:0] queue_limit;
  logic                        playback_paused;

  logic                 accept;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [2*STORE_W-1:0] rd_data;
  sfbd_pkg::status_t    status;

  logic              s1_valid;
  sfbd_pkg::status_t s1_status;
  logic              s1_move;
  logic              out_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit     <= sfbd_pkg::QUEUE_LIMIT_RST;
      playback_paused <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sfbd_pkg::REG_QUEUE_LIMIT:     queue_limit     <= cfg_data;
        sfbd_pkg::REG_PLAYBACK_PAUSED: playback_paused <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign out_take  = rsp_valid && !rsp_stall;
  assign s1_move   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  sfbd_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .cmd             (req.cmd),
    .queue_limit     (queue_limit),
    .playback_paused (playback_paused),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .status          (status)
  );

  sfbd_ring_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (2 * STORE_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({req.in_left[STORE_W-1:0], req.in_right[STORE_W-1:0]}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Read data stays put until the next popping transfer, which cannot happen while s1 holds an item that does not move.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_move) begin
      rsp_valid <= 1'b1;
    end else if (out_take) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp.out_left       <= s1_status.pop ? SAMPLE_W'(rd_data[2*STORE_W-1:STORE_W]) : '0;
      rsp.out_right      <= s1_status.pop ? SAMPLE_W'(rd_data[STORE_W-1:0]) : '0;
      rsp.accepted       <= s1_status.accepted;
      rsp.fill_level     <= s1_status.fill_level;
      rsp.underrun_total <= s1_status.underrun_total;
      rsp.overrun_total  <= s1_status.overrun_total;
      rsp.fill_min       <= s1_status.fill_min;
      rsp.fill_max       <= s1_status.fill_max;
      rsp.refill_total   <= s1_status.refill_total;
      rsp.silence_total  <= s1_status.silence_total;
    end
  end

  // Fill extremes bracket the fill whenever the 13-bit fields are not truncated.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (RING_DEPTH < 8192) |->
      (rsp.fill_min <= rsp.fill_level) && (rsp.fill_level <= rsp.fill_max))
    else $error("fill_min/fill_max do not bracket fill_level");

  // A stored write never carries sample data and never reports an empty queue.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.accepted && (RING_DEPTH < 8192) |->
      (rsp.out_left == '0) && (rsp.out_right == '0) && (rsp.fill_level != '0))
    else $error("stored write reported samples or empty fill");

  // Hold the pending item in s1 while the output stage is blocked.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && rsp_valid && rsp_stall |=> s1_valid && rsp_valid)
    else $error("pending item dropped during output stall");

endmodule

// ===== src/sfbd_ring_ram.sv =====
`timescale 1ns / 1ps

module sfbd_ring_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/sfbd_ctrl.sv =====
`timescale 1ns / 1ps

module sfbd_ctrl #(
  parameter int RING_DEPTH = sfbd_pkg::RING_DEPTH_DEF,
  parameter int BLOCK_SIZE = sfbd_pkg::BLOCK_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [1:0]                      cmd,
  input  logic [sfbd_pkg::FILL_W-1:0]     queue_limit,
  input  logic                            playback_paused,
  output logic                            wr_en,
  output logic [$clog2(RING_DEPTH)-1:0]   wr_addr,
  output logic                            rd_en,
  output logic [$clog2(RING_DEPTH)-1:0]   rd_addr,
  output sfbd_pkg::status_t               status
);

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int BLK_W  = $clog2(BLOCK_SIZE);
  localparam int TAKE_W = $clog2(BLOCK_SIZE + 1);
  localparam int STAT_W = sfbd_pkg::STAT_W;
  localparam int FILL_W = sfbd_pkg::FILL_W;

  logic [IDX_W-1:0]  write_index, write_index_next;
  logic [IDX_W-1:0]  read_index, read_index_next;
  logic [CNT_W-1:0]  queued_count, queued_count_next;
  logic [BLK_W-1:0]  block_position, block_position_next;
  logic [TAKE_W-1:0] take_remaining, take_remaining_next;
  logic [STAT_W-1:0] underrun_count, underrun_count_next;
  logic [STAT_W-1:0] overrun_count, overrun_count_next;
  logic [STAT_W-1:0] refill_tally, refill_tally_next;
  logic [STAT_W-1:0] silent_count, silent_count_next;
  logic [CNT_W-1:0]  min_fill, min_fill_next;
  logic [CNT_W-1:0]  max_fill, max_fill_next;

  logic              full;
  logic              block_start;
  logic [TAKE_W-1:0] take_raw;
  logic [TAKE_W-1:0] take_eff;
  logic              pop;
  logic              note;
  logic              stored;

  // Effective limit is the lesser of the register and the ring depth.
  assign full = (32'(queued_count) >= 32'(queue_limit)) ||
                (32'(queued_count) >= RING_DEPTH);
  assign block_start = (block_position == '0);
  assign take_raw = (32'(queued_count) > BLOCK_SIZE) ? TAKE_W'(BLOCK_SIZE)
                                                     : TAKE_W'(queued_count);
  assign take_eff = block_start ? (playback_paused ? '0 : take_raw) : take_remaining;

  always_comb begin
    write_index_next    = write_index;
    read_index_next     = read_index;
    queued_count_next   = queued_count;
    block_position_next = block_position;
    take_remaining_next = take_remaining;
    underrun_count_next = underrun_count;
    overrun_count_next  = overrun_count;
    refill_tally_next   = refill_tally;
    silent_count_next   = silent_count;
    min_fill_next       = min_fill;
    max_fill_next       = max_fill;
    pop                 = 1'b0;
    note                = 1'b0;
    stored              = 1'b0;
    unique case (cmd)
      sfbd_pkg::CMD_WRITE: begin
        if (full) begin
          overrun_count_next = overrun_count + 1'b1;
        end else begin
          stored            = 1'b1;
          note              = 1'b1;
          write_index_next  = (write_index == IDX_W'(RING_DEPTH - 1)) ? '0
                                                                      : write_index + 1'b1;
          queued_count_next = queued_count + 1'b1;
        end
      end
      sfbd_pkg::CMD_READ: begin
        if (block_start && !playback_paused) begin
          refill_tally_next = refill_tally + 1'b1;
          if (32'(take_raw) < BLOCK_SIZE) begin
            underrun_count_next = underrun_count + 1'b1;
            silent_count_next   = silent_count + (STAT_W'(BLOCK_SIZE) - STAT_W'(take_raw));
          end
        end
        pop = !playback_paused && (take_eff != '0) && (queued_count != '0);
        take_remaining_next = take_eff - TAKE_W'(pop);
        if (pop) begin
          note              = 1'b1;
          read_index_next   = (read_index == IDX_W'(RING_DEPTH - 1)) ? '0
                                                                     : read_index + 1'b1;
          queued_count_next = queued_count - 1'b1;
        end
        block_position_next = (block_position == BLK_W'(BLOCK_SIZE - 1)) ? '0
                                                                         : block_position + 1'b1;
      end
      sfbd_pkg::CMD_FLUSH: begin
        note                = 1'b1;
        write_index_next    = '0;
        read_index_next     = '0;
        queued_count_next   = '0;
        take_remaining_next = '0;
      end
      sfbd_pkg::CMD_RESET_STATS: begin
        underrun_count_next = '0;
        overrun_count_next  = '0;
        refill_tally_next   = '0;
        silent_count_next   = '0;
        min_fill_next       = queued_count;
        max_fill_next       = queued_count;
      end
      default: begin
      end
    endcase
    if (note) begin
      if (queued_count_next < min_fill) begin
        min_fill_next = queued_count_next;
      end
      if (queued_count_next > max_fill) begin
        max_fill_next = queued_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index    <= '0;
      read_index     <= '0;
      queued_count   <= '0;
      block_position <= '0;
      take_remaining <= '0;
      underrun_count <= '0;
      overrun_count  <= '0;
      refill_tally   <= '0;
      silent_count   <= '0;
      min_fill       <= '0;
      max_fill       <= '0;
    end else if (accept) begin
      write_index    <= write_index_next;
      read_index     <= read_index_next;
      queued_count   <= queued_count_next;
      block_position <= block_position_next;
      take_remaining <= take_remaining_next;
      underrun_count <= underrun_count_next;
      overrun_count  <= overrun_count_next;
      refill_tally   <= refill_tally_next;
      silent_count   <= silent_count_next;
      min_fill       <= min_fill_next;
      max_fill       <= max_fill_next;
    end
  end

  assign wr_en   = accept && stored;
  assign wr_addr = write_index;
  assign rd_en   = accept && pop;
  assign rd_addr = read_index;

  always_comb begin
    status.accepted       = stored;
    status.pop            = pop;
    status.fill_level     = FILL_W'(queued_count_next);
    status.underrun_total = underrun_count_next;
    status.overrun_total  = overrun_count_next;
    status.fill_min       = FILL_W'(min_fill_next);
    status.fill_max       = FILL_W'(max_fill_next);
    status.refill_total   = refill_tally_next;
    status.silence_total  = silent_count_next;
  end

endmodule
